>>> rtl/core/ncl_pkg.sv
`default_nettype none
package ncl_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_DRAIN,
        ST_FLUSH,
        ST_RESULT,
        ST_CLEAR
    } ncl_state_t;

    // controls shared by every cell of both chains
    typedef struct packed {
        logic clear;
        logic drain;
    } cell_ctrl_t;

    localparam int unsigned COUNT_BITS = 7;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 7'd127;

endpackage
`default_nettype wire

>>> rtl/core/ncl_sort_cell.sv
`default_nettype none
module ncl_sort_cell #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  ncl_pkg::cell_ctrl_t      ctrl,
    input  wire                      in_valid,
    input  wire  [POSITION_BITS-1:0] in_a,
    input  wire  [POSITION_BITS-1:0] in_b,
    input  wire                      nbr_valid,
    input  wire  [POSITION_BITS-1:0] nbr_a,
    input  wire  [POSITION_BITS-1:0] nbr_b,
    output logic                     held_valid,
    output logic [POSITION_BITS-1:0] held_a,
    output logic [POSITION_BITS-1:0] held_b,
    output logic                     pass_valid,
    output logic [POSITION_BITS-1:0] pass_a,
    output logic [POSITION_BITS-1:0] pass_b
);

    logic                     hv_reg, hv_next, pv_reg, pv_next;
    logic [POSITION_BITS-1:0] ha_reg, ha_next, hb_reg, hb_next;
    logic [POSITION_BITS-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic                     in_less;

    assign in_less = {in_a, in_b} < {ha_reg, hb_reg};

    // clear, drain, else keep smaller, pass larger on
    always_comb
    begin
        hv_next = hv_reg;
        ha_next = ha_reg;
        hb_next = hb_reg;
        pv_next = 1'b0;
        pa_next = in_a;
        pb_next = in_b;
        if (ctrl.clear)
        begin
            hv_next = 1'b0;
        end
        else if (ctrl.drain)
        begin
            hv_next = nbr_valid;
            ha_next = nbr_a;
            hb_next = nbr_b;
        end
        else if (in_valid)
        begin
            pv_next = hv_reg;
            if (!hv_reg || in_less)
            begin
                hv_next = 1'b1;
                ha_next = in_a;
                hb_next = in_b;
                pa_next = ha_reg;
                pb_next = hb_reg;
            end
            else
            begin
                pv_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= 1'b0;
            pv_reg <= 1'b0;
        end
        else
        begin
            hv_reg <= hv_next;
            pv_reg <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ha_reg <= ha_next;
        hb_reg <= hb_next;
        pa_reg <= pa_next;
        pb_reg <= pb_next;
    end

    assign held_valid = hv_reg;
    assign held_a     = ha_reg;
    assign held_b     = hb_reg;
    assign pass_valid = pv_reg;
    assign pass_a     = pa_reg;
    assign pass_b     = pb_reg;

endmodule
`default_nettype wire

>>> rtl/core/ncl_run_cell.sv
`default_nettype none
module ncl_run_cell #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  ncl_pkg::cell_ctrl_t      ctrl,
    input  wire                      in_valid,
    input  wire  [POSITION_BITS-1:0] in_b,
    output logic                     pass_valid,
    output logic [POSITION_BITS-1:0] pass_b,
    output logic                     filled
);

    logic                     tv_reg, tv_next, pv_reg, pv_next;
    logic [POSITION_BITS-1:0] tail_reg, tail_next, pb_reg;

    // clear empties the slot; else take an empty slot, replace a tail that is not smaller, else pass on
    always_comb
    begin
        tv_next   = tv_reg;
        tail_next = tail_reg;
        pv_next   = 1'b0;
        filled    = 1'b0;
        if (ctrl.clear)
        begin
            tv_next = 1'b0;
        end
        else if (in_valid)
        begin
            if (!tv_reg)
            begin
                tv_next   = 1'b1;
                tail_next = in_b;
                filled    = 1'b1;
            end
            else if (tail_reg >= in_b)
            begin
                tail_next = in_b;
            end
            else
            begin
                pv_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= 1'b0;
            pv_reg <= 1'b0;
        end
        else
        begin
            tv_reg <= tv_next;
            pv_reg <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
        pb_reg   <= in_b;
    end

    assign pass_valid = pv_reg;
    assign pass_b     = pb_reg;

endmodule
`default_nettype wire

>>> rtl/core/non_crossing_links_counter.sv
// Non-crossing links counter.
// Input channel: in_valid / in_stall carrying side_a_position, side_b_position
// and last_pair. Pairs are taken one per cycle while the block is loading.
// A request with last_pair set closes the set and starts the computation;
// in_stall stays high until the result has been taken and the chains cleared.
// Output channel: out_valid / out_stall carrying link_count and overflow, one
// result per set. The result is held in its register while out_stall is high.
// Pairs beyond MAX_PAIRS are dropped and reported through overflow.
// After the last pair the sorting chain settles, the n stored pairs stream out
// of its head into the run chain, the run chain settles, and out_valid rises;
// the two cell chains set this latency. A set of n pairs occupies the block
// while it loads, for that sequence, and for a clear of the chains after the
// result leaves.
// Reset empties both chains and returns the block to loading.
`default_nettype none
module non_crossing_links_counter #(
    parameter int unsigned MAX_PAIRS     = 64,
    parameter int unsigned POSITION_BITS = 16
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_stall,
    input  wire  [POSITION_BITS-1:0] side_a_position,
    input  wire  [POSITION_BITS-1:0] side_b_position,
    input  wire                      last_pair,
    output logic                     out_valid,
    input  wire                      out_stall,
    output logic [6:0]               link_count,
    output logic                     overflow
);

    localparam int unsigned CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int unsigned TMR_W = $clog2(MAX_PAIRS + 2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PAIRS);

    ncl_pkg::ncl_state_t state_reg, state_next;
    logic [CNT_W-1:0]    pair_count_reg, pair_count_next;
    logic                ovf_reg, ovf_next;
    logic [TMR_W-1:0]    timer_reg, timer_next;
    logic [ncl_pkg::COUNT_BITS-1:0] run_reg, run_next;
    ncl_pkg::cell_ctrl_t ctrl;
    logic                accept, store_pair, emit;

    logic [MAX_PAIRS:0]                     sv, pv;
    logic [MAX_PAIRS:0][POSITION_BITS-1:0]  sa, sb, pa, pb;
    logic [MAX_PAIRS:0]                     rv;
    logic [MAX_PAIRS:0][POSITION_BITS-1:0]  rb;
    logic [MAX_PAIRS-1:0]                   fill_vec;

    assign accept     = in_valid && !in_stall;
    assign store_pair = accept && (pair_count_reg < CNT_FULL);
    assign emit       = (state_reg == ncl_pkg::ST_DRAIN) && (timer_reg != '0);

    // feed the sorting chain from the input, and the run chain from its head
    assign pv[0] = store_pair;
    assign pa[0] = side_a_position;
    assign pb[0] = side_b_position;
    assign sv[MAX_PAIRS] = 1'b0;
    assign sa[MAX_PAIRS] = '0;
    assign sb[MAX_PAIRS] = '0;
    assign rv[0] = emit && sv[0];
    assign rb[0] = sb[0];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PAIRS; gi++)
        begin : g_cells
            ncl_sort_cell #(.POSITION_BITS(POSITION_BITS)) u_sort (
                .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
                .in_valid(pv[gi]), .in_a(pa[gi]), .in_b(pb[gi]),
                .nbr_valid(sv[gi+1]), .nbr_a(sa[gi+1]), .nbr_b(sb[gi+1]),
                .held_valid(sv[gi]), .held_a(sa[gi]), .held_b(sb[gi]),
                .pass_valid(pv[gi+1]), .pass_a(pa[gi+1]), .pass_b(pb[gi+1])
            );
            ncl_run_cell #(.POSITION_BITS(POSITION_BITS)) u_run (
                .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
                .in_valid(rv[gi]), .in_b(rb[gi]),
                .pass_valid(rv[gi+1]), .pass_b(rb[gi+1]),
                .filled(fill_vec[gi])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ncl_pkg::ST_LOAD:
                if (accept && last_pair)
                    state_next = ncl_pkg::ST_SETTLE;
            ncl_pkg::ST_SETTLE:
                if (timer_reg == '0)
                    state_next = ncl_pkg::ST_DRAIN;
            ncl_pkg::ST_DRAIN:
                if (timer_reg == '0)
                    state_next = ncl_pkg::ST_FLUSH;
            ncl_pkg::ST_FLUSH:
                if (timer_reg == '0)
                    state_next = ncl_pkg::ST_RESULT;
            ncl_pkg::ST_RESULT:
                if (!out_stall)
                    state_next = ncl_pkg::ST_CLEAR;
            ncl_pkg::ST_CLEAR:
                state_next = ncl_pkg::ST_LOAD;
            default:
                state_next = ncl_pkg::ST_LOAD;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        in_stall        = (state_reg != ncl_pkg::ST_LOAD);
        out_valid       = (state_reg == ncl_pkg::ST_RESULT);
        ctrl.clear      = (state_reg == ncl_pkg::ST_CLEAR);
        ctrl.drain      = emit;
        pair_count_next = pair_count_reg;
        ovf_next        = ovf_reg;
        timer_next      = timer_reg;
        run_next        = run_reg;
        unique case (state_reg)
            ncl_pkg::ST_LOAD:
            begin
                if (store_pair)
                    pair_count_next = pair_count_reg + CNT_W'(1);
                if (accept && !store_pair)
                    ovf_next = 1'b1;
                timer_next = TMR_W'(MAX_PAIRS);
                run_next   = '0;
            end
            ncl_pkg::ST_SETTLE:
            begin
                timer_next = (timer_reg == '0) ? TMR_W'(pair_count_reg)
                                               : timer_reg - TMR_W'(1);
            end
            ncl_pkg::ST_DRAIN:
            begin
                timer_next = (timer_reg == '0) ? TMR_W'(MAX_PAIRS + 1)
                                               : timer_reg - TMR_W'(1);
            end
            ncl_pkg::ST_FLUSH:
            begin
                if (timer_reg != '0)
                    timer_next = timer_reg - TMR_W'(1);
            end
            ncl_pkg::ST_RESULT:
            begin
                if (!out_stall)
                begin
                    pair_count_next = '0;
                    ovf_next        = 1'b0;
                end
            end
            ncl_pkg::ST_CLEAR:
            begin
                timer_next = TMR_W'(MAX_PAIRS);
            end
            default:
            begin
                timer_next = timer_reg;
            end
        endcase
        // count each newly opened run slot, saturating
        if (|fill_vec && run_reg != ncl_pkg::COUNT_MAX)
            run_next = run_reg + 7'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ncl_pkg::ST_LOAD;
            pair_count_reg <= '0;
            ovf_reg        <= 1'b0;
            timer_reg      <= '0;
            run_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pair_count_reg <= pair_count_next;
            ovf_reg        <= ovf_next;
            timer_reg      <= timer_next;
            run_reg        <= run_next;
        end
    end

    assign link_count = run_reg;
    assign overflow   = ovf_reg;

    a_one_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(fill_vec))
        else $error("more than one run slot opened in a cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pair_count_reg <= CNT_FULL)
        else $error("pair count beyond capacity");

    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (pair_count_reg == '0 && !ovf_reg))
        else $error("set state not cleared after result");

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    localparam int unsigned PAIR_CAP = 64;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [6:0] link_count;
        logic       overflow;
    } link_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] side_a_position;
    logic [15:0] side_b_position;
    logic        last_pair;
    logic        out_valid;
    logic        out_stall;
    logic [6:0]  link_count;
    logic        overflow;

    // predictor state: pairs of the open set
    logic [15:0]  set_a[$];
    logic [15:0]  set_b[$];
    logic         set_dropped;
    link_result_t expected_links[$];
    int unsigned  error_count;
    int unsigned  cycle_count;
    int unsigned  out_wait;
    bit           hold_off;
    bit           random_stall;

    non_crossing_links_counter #(
        .MAX_PAIRS(PAIR_CAP),
        .POSITION_BITS(16)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .side_a_position(side_a_position),
        .side_b_position(side_b_position),
        .last_pair(last_pair),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .link_count(link_count),
        .overflow(overflow)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // sort by A then B, then longest strictly increasing B run
    function automatic logic [6:0] count_non_crossing();
        logic [15:0] a[$];
        logic [15:0] b[$];
        int          run[$];
        logic [15:0] ka;
        logic [15:0] kb;
        int          j;
        int          len;
        int          best;
        a = set_a;
        b = set_b;
        best = 0;
        for (int i = 1; i < a.size(); i++)
        begin
            ka = a[i];
            kb = b[i];
            j = i;
            while (j > 0 && (a[j-1] > ka || (a[j-1] == ka && b[j-1] > kb)))
            begin
                a[j] = a[j-1];
                b[j] = b[j-1];
                j--;
            end
            a[j] = ka;
            b[j] = kb;
        end
        for (int i = 0; i < a.size(); i++)
        begin
            len = 1;
            for (int k = 0; k < i; k++)
                if (b[k] < b[i] && run[k] + 1 > len)
                    len = run[k] + 1;
            if (len > 127)
                len = 127;
            run = {run, len};
            if (len > best)
                best = len;
        end
        return best[6:0];
    endfunction

    // apply one accepted request to the predictor
    function automatic void predict_pair(logic [15:0] a, logic [15:0] b, logic fin);
        link_result_t r;
        if (set_a.size() < PAIR_CAP)
        begin
            set_a = {set_a, a};
            set_b = {set_b, b};
        end
        else
            set_dropped = 1'b1;
        if (fin)
        begin
            r.link_count = count_non_crossing();
            r.overflow = set_dropped;
            expected_links = {expected_links, r};
            set_a.delete();
            set_b.delete();
            set_dropped = 1'b0;
        end
    endfunction

    // offer one request after a random gap (when gaps is set) and hold it until taken
    task automatic send_pair(logic [15:0] a, logic [15:0] b, logic fin, bit gaps = 1);
        int gap;
        gap = gaps ? int'($urandom_range(0, 5)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        side_a_position <= a;
        side_b_position <= b;
        last_pair <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pair(a, b, fin);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_results();
        drop_valid();
        while (expected_links.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_set(int n, int a_max, int b_max);
        for (int i = 0; i < n; i++)
            send_pair(16'($urandom_range(0, a_max)), 16'($urandom_range(0, b_max)),
                      i == n - 1);
    endtask

    task automatic test_single_pairs();
        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'hFFFF, 16'hFFFF, 1'b1);
        send_pair(16'hAAAA, 16'h5555, 1'b1);
        send_pair(16'h5555, 16'hAAAA, 1'b1);
        wait_results();
    endtask

    task automatic test_ties_and_order();
        // equal pairs count once
        send_pair(16'd7, 16'd9, 1'b0);
        send_pair(16'd7, 16'd9, 1'b1);
        // same A, rising B: all three count
        send_pair(16'd3, 16'd1, 1'b0);
        send_pair(16'd3, 16'd2, 1'b0);
        send_pair(16'd3, 16'd3, 1'b1);
        // fully crossing set
        send_pair(16'd1, 16'hFFFF, 1'b0);
        send_pair(16'd2, 16'd100, 1'b0);
        send_pair(16'hFFFF, 16'd0, 1'b1);
        // increasing, offered out of order
        send_pair(16'd30, 16'd3, 1'b0);
        send_pair(16'd10, 16'd1, 1'b0);
        send_pair(16'd20, 16'd2, 1'b1);
        wait_results();
    endtask

    task automatic test_full_and_overflow();
        // exactly full, all increasing
        for (int i = 0; i < PAIR_CAP; i++)
            send_pair(i[15:0], i[15:0] + 16'd1, i == PAIR_CAP - 1, 0);
        // overflow with a dropped final pair
        for (int i = 0; i <= PAIR_CAP; i++)
            send_pair(16'hFFFF - i[15:0], i[15:0], i == PAIR_CAP, 0);
        wait_results();
    endtask

    task automatic test_random_sets();
        int sent;
        int n;
        sent = 0;
        while (sent < 1600)
        begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(PAIR_CAP - 2, PAIR_CAP + 6);
                1: n = 1;
                default: n = $urandom_range(2, 16);
            endcase
            if ($urandom_range(0, 1))
                send_random_set(n, 65535, 65535);
            else
                send_random_set(n, 15, 15);
            sent += n;
        end
        wait_results();
    endtask

    task automatic test_output_backpressure();
        // stall the result side while offering more sets
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                send_random_set(8, 255, 255);
                send_random_set(8, 255, 255);
                send_random_set(5, 65535, 65535);
            end
        join
        wait_results();
    endtask

    // drive the result-side stall: hold_off, plus a wait drawn after each taken result when random_stall is set
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_wait = 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                out_wait = random_stall ? $urandom_range(0, 5) : 0;
            else if (out_valid && out_wait != 0)
                out_wait = out_wait - 1;
            out_stall <= hold_off || (out_wait != 0);
        end
    end

    // check each result against the oldest expectation
    always @(posedge clk)
    begin
        link_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_links.size() == 0)
            begin
                $error("unexpected result link_count=%0d overflow=%0d", link_count, overflow);
                error_count++;
            end
            else
            begin
                exp_r = expected_links.pop_front();
                if (link_count !== exp_r.link_count)
                begin
                    $error("link_count expected %0d actual %0d", exp_r.link_count, link_count);
                    error_count++;
                end
                if (overflow !== exp_r.overflow)
                begin
                    $error("overflow expected %0d actual %0d", exp_r.overflow, overflow);
                    error_count++;
                end
            end
        end
    end

    // bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        side_a_position = '0;
        side_b_position = '0;
        last_pair = 1'b0;
        out_stall = 1'b0;
        set_dropped = 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_off = 1'b0;
        random_stall = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_pairs();
        random_stall = 1'b1;
        test_ties_and_order();
        random_stall = 1'b0;
        test_full_and_overflow();
        random_stall = 1'b1;
        test_random_sets();
        test_output_backpressure();
        repeat (300) @(posedge clk);
        if (error_count == 0 && expected_links.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
